// ----- src/min_square_sum_count_top_assert.svh -----
// assertion macros used by the checker file
`ifndef MIN_SQUARE_SUM_COUNT_TOP_ASSERT_SVH
`define MIN_SQUARE_SUM_COUNT_TOP_ASSERT_SVH

// same-cycle implication, sampled on aclk, off while in reset
`define MSQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off while in reset
`define MSQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/msq_pkg.sv -----
`default_nettype none

package msq_pkg;

    // field widths
    localparam int QUERY_W = 12;
    localparam int COUNT_W = 3;
    localparam int ROOT_W  = 7;
    // holds (root + 1)^2 for every root reached
    localparam int SQ_W    = 13;

    localparam int DEFAULT_TABLE_DEPTH = 4096;

    // saturated start count and first entry filled by search
    localparam logic [COUNT_W-1:0] START_COUNT = 3'd7;
    localparam logic [COUNT_W-1:0] ONE_COUNT   = 3'd1;
    localparam logic [COUNT_W-1:0] ERROR_COUNT = 3'd0;
    localparam logic [QUERY_W-1:0] FILL_START  = 12'd4;

    // sequencer states
    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SQCHK  = 7'b0000010,
        ST_INIT   = 7'b0000100,
        ST_READ   = 7'b0001000,
        ST_DRAIN  = 7'b0010000,
        ST_FINISH = 7'b0100000,
        ST_SPARE  = 7'b1000000
    } msq_state_t;

endpackage

`default_nettype wire

// ----- src/msq_table.sv -----
`default_nettype none

module msq_table #(
    parameter int DEPTH  = msq_pkg::DEFAULT_TABLE_DEPTH,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = msq_pkg::COUNT_W
) (
    input  wire logic              aclk,
    input  wire logic              mem_en,
    input  wire logic              mem_we,
    input  wire logic [ADDR_W-1:0] mem_addr,
    input  wire logic [DATA_W-1:0] mem_wdata,
    output logic      [DATA_W-1:0] mem_rdata
);

    logic [DATA_W-1:0] mem_array [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // single port, read data registered
    always_ff @(posedge aclk) begin
        if (mem_en) begin
            if (mem_we) begin
                mem_array[mem_addr] <= mem_wdata;
            end else begin
                rdata_reg <= mem_array[mem_addr];
            end
        end
    end

    assign mem_rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- src/msq_ctrl.sv -----
`default_nettype none

module msq_ctrl #(
    parameter int TABLE_DEPTH = msq_pkg::DEFAULT_TABLE_DEPTH,
    parameter int ADDR_W      = $clog2(TABLE_DEPTH)
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [msq_pkg::QUERY_W-1:0] s_query_value,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic      [msq_pkg::COUNT_W-1:0] m_square_count,
    output logic                             mem_en,
    output logic                             mem_we,
    output logic      [ADDR_W-1:0]           mem_addr,
    output logic      [msq_pkg::COUNT_W-1:0] mem_wdata,
    input  wire logic [msq_pkg::COUNT_W-1:0] mem_rdata
);

    import msq_pkg::*;

    msq_state_t         state_reg, state_next;
    logic [QUERY_W-1:0] query_reg, query_next;
    logic [QUERY_W-1:0] idx_reg, idx_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    logic [SQ_W-1:0]    sq_reg, sq_next;
    logic [COUNT_W-1:0] best_reg, best_next;
    logic               pend_reg, pend_next;
    logic [COUNT_W-1:0] result_reg, result_next;
    logic               out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;

    logic [COUNT_W-1:0] cand;
    logic [COUNT_W-1:0] merged;
    logic [SQ_W-1:0]    step_sq;
    logic [SQ_W-1:0]    query_ext;
    logic [SQ_W-1:0]    idx_ext;
    logic [SQ_W-1:0]    read_off;

    // candidate from the word read last cycle, saturating increment
    assign cand   = (mem_rdata == START_COUNT) ? START_COUNT : mem_rdata + COUNT_W'(1);
    assign merged = (pend_reg && (cand < best_reg)) ? cand : best_reg;

    // next square from the current one: (x + 1)^2 = x^2 + 2x + 1
    assign step_sq   = sq_reg + SQ_W'({root_reg, 1'b1});
    assign query_ext = SQ_W'(query_reg);
    assign idx_ext   = SQ_W'(idx_reg);
    assign read_off  = idx_ext - sq_reg;

    // sequencer
    always_comb begin
        state_next     = state_reg;
        query_next     = query_reg;
        idx_next       = idx_reg;
        root_next      = root_reg;
        sq_next        = sq_reg;
        best_next      = best_reg;
        pend_next      = pend_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg;
        out_count_next = out_count_reg;
        s_ready        = 1'b0;
        mem_en         = 1'b0;
        mem_we         = 1'b0;
        mem_addr       = ADDR_W'(idx_reg);
        mem_wdata      = merged;

        // output word taken
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    query_next = s_query_value;
                    root_next  = '0;
                    sq_next    = '0;
                    state_next = ST_SQCHK;
                end
            end
            // walk squares up to the query to test for a perfect square, then finish early or start the fill
            ST_SQCHK: begin
                if (sq_reg >= query_ext) begin
                    if (sq_reg == query_ext) begin
                        result_next = ONE_COUNT;
                        state_next  = ST_FINISH;
                    end else if (32'(query_reg) >= 32'(TABLE_DEPTH)) begin
                        result_next = ERROR_COUNT;
                        state_next  = ST_FINISH;
                    end else if (query_reg < FILL_START) begin
                        result_next = query_reg[COUNT_W-1:0];
                        state_next  = ST_FINISH;
                    end else begin
                        idx_next   = '0;
                        state_next = ST_INIT;
                    end
                end else begin
                    root_next = root_reg + ROOT_W'(1);
                    sq_next   = step_sq;
                end
            end
            // seed entries below the first searched one with their own index
            ST_INIT: begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_wdata = idx_reg[COUNT_W-1:0];
                if (idx_reg == FILL_START - QUERY_W'(1)) begin
                    idx_next   = FILL_START;
                    root_next  = ROOT_W'(1);
                    sq_next    = SQ_W'(1);
                    best_next  = START_COUNT;
                    pend_next  = 1'b0;
                    state_next = ST_READ;
                end else begin
                    idx_next = idx_reg + QUERY_W'(1);
                end
            end
            // one table read per root, fold in the previous read
            ST_READ: begin
                mem_en    = 1'b1;
                mem_addr  = ADDR_W'(read_off);
                best_next = merged;
                pend_next = 1'b1;
                root_next = root_reg + ROOT_W'(1);
                sq_next   = step_sq;
                if (step_sq > idx_ext) begin
                    state_next = ST_DRAIN;
                end
            end
            // fold in the last read and write the entry back
            ST_DRAIN: begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                pend_next = 1'b0;
                if (idx_reg == query_reg) begin
                    result_next = merged;
                    state_next  = ST_FINISH;
                end else begin
                    idx_next   = idx_reg + QUERY_W'(1);
                    root_next  = ROOT_W'(1);
                    sq_next    = SQ_W'(1);
                    best_next  = START_COUNT;
                    state_next = ST_READ;
                end
            end
            // hand the result to the output register
            ST_FINISH: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    out_count_next = result_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        query_reg     <= query_next;
        idx_reg       <= idx_next;
        root_reg      <= root_next;
        sq_reg        <= sq_next;
        best_reg      <= best_next;
        result_reg    <= result_next;
        out_count_reg <= out_count_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_square_count = out_count_reg;

endmodule

`default_nettype wire

// ----- src/min_square_sum_count_top.sv -----
// fewest perfect squares summing to a query, count table in one single-port ram
// squares, n >= TABLE_DEPTH and n < 4 are answered after the square walk alone;
// otherwise entries 4 to n are filled in turn, with one table read per root of
// each entry in the fill loop, so the run time grows with n
// throughput: one word at a time; next word taken once the result is registered
// reset: synchronous, clears control state only; table contents are not cleared
`default_nettype none

module min_square_sum_count_top #(
    parameter int TABLE_DEPTH = msq_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [msq_pkg::QUERY_W-1:0] s_query_value,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic      [msq_pkg::COUNT_W-1:0] m_square_count
);

    import msq_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    logic               mem_en;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_addr;
    logic [COUNT_W-1:0] mem_wdata;
    logic [COUNT_W-1:0] mem_rdata;

    // fill sequencer
    msq_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_query_value  (s_query_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_square_count (m_square_count),
        .mem_en         (mem_en),
        .mem_we         (mem_we),
        .mem_addr       (mem_addr),
        .mem_wdata      (mem_wdata),
        .mem_rdata      (mem_rdata)
    );

    // count table
    msq_table #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (COUNT_W)
    ) u_table (
        .aclk      (aclk),
        .mem_en    (mem_en),
        .mem_we    (mem_we),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

endmodule

`default_nettype wire

// ----- src/msq_checker.sv -----
`default_nettype none

`include "min_square_sum_count_top_assert.svh"

module msq_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_valid,
    input wire logic                        s_ready,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic [msq_pkg::COUNT_W-1:0] m_square_count
);

    // stalled result word holds
    `MSQ_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_square_count), "result word changed while stalled")

    // counts never exceed four
    `MSQ_ASSERT_IMP(a_out_range, m_valid, m_square_count <= 3'd4, "result count out of range")

    // one query at a time
    `MSQ_ASSERT_NXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "input taken again while busy")

    // no result appears in the cycle right after a query is taken
    `MSQ_ASSERT_NXT(a_no_instant_result, s_valid && s_ready && !m_valid, !m_valid, "result appeared without work")

endmodule

bind min_square_sum_count_top msq_checker u_msq_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_square_count (m_square_count)
);

`default_nettype wire

// ----- dv/min_square_sum_count_top_tb.sv -----
module min_square_sum_count_top_tb;

    localparam int TABLE_DEPTH = msq_pkg::DEFAULT_TABLE_DEPTH;
    localparam int QW = msq_pkg::QUERY_W;
    localparam int CW = msq_pkg::COUNT_W;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    logic [QW-1:0] s_query_value = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    logic [CW-1:0] m_square_count;

    // counts expected back, oldest first
    logic [CW-1:0] pending_counts[$];
    int unsigned   mismatch_count = 0;

    // idle odds in percent, and a forced result-side hold in cycles
    int unsigned   send_idle_pct = 27;
    int unsigned   recv_idle_pct = 45;
    int unsigned   hold_cycles_left = 0;

    min_square_sum_count_top #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_query_value (s_query_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_square_count(m_square_count)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // run limit, several times the slowest legal run
    initial begin
        #(2 * 4_000_000);
        $display("[min_square_sum_count_top] ERROR");
        $finish;
    end

    // fewest squares summing to n, by a bottom-up count table
    function automatic logic [CW-1:0] fewest_squares(input logic [QW-1:0] n);
        logic [CW-1:0] counts [TABLE_DEPTH];
        logic [CW-1:0] best;
        logic [CW-1:0] cand;
        int unsigned   nv;
        int unsigned   r;
        int unsigned   i;
        int unsigned   x;
        nv = 32'(n);
        r = 0;
        while (r * r < nv) r++;
        if (r * r == nv) return msq_pkg::ONE_COUNT;
        if (nv >= TABLE_DEPTH) return msq_pkg::ERROR_COUNT;
        counts[0] = 3'd0;
        counts[1] = 3'd1;
        counts[2] = 3'd2;
        counts[3] = 3'd3;
        for (i = 32'(msq_pkg::FILL_START); i <= nv; i++) begin
            best = msq_pkg::START_COUNT;
            for (x = 1; x * x <= i; x++) begin
                // saturating add of one square
                if (counts[i - x * x] >= msq_pkg::START_COUNT) begin
                    cand = msq_pkg::START_COUNT;
                end else begin
                    cand = counts[i - x * x] + 3'd1;
                end
                if (cand < best) best = cand;
            end
            counts[i] = best;
        end
        return counts[nv];
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("mismatch: %s, expected %0d, got %0d, at %0t", what, want, got, $time);
        mismatch_count++;
    endtask

    // offer one query word and hold it until taken; valid stays up for the next call
    task automatic send_query(input logic [QW-1:0] n);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_query_value <= n;
        do @(posedge aclk); while (!s_ready);
        pending_counts.push_back(fewest_squares(n));
    endtask

    // result side ready, with random idles and forced holds
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_cycles_left > 0) begin
            hold_cycles_left = hold_cycles_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // compare each accepted result word with the oldest expected count
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_counts.size() == 0) begin
                report_mismatch("result word with nothing pending", 0, 32'(m_square_count));
            end else if (m_square_count !== pending_counts[0]) begin
                report_mismatch("square_count", 32'(pending_counts[0]), 32'(m_square_count));
                void'(pending_counts.pop_front());
            end else begin
                void'(pending_counts.pop_front());
            end
        end
    end

    // small values, zero, answers 1 to 4, single high bit, all ones, large squares
    task automatic test_corner_queries();
        int unsigned corners [25] = '{
            0, 1, 2, 3, 4, 5, 6, 7, 8, 12, 13, 15, 23, 28, 31, 48,
            63, 112, 127, 128, 255, 1024, 2048, 3969, 4095
        };
        foreach (corners[k]) begin
            send_query(QW'(corners[k]));
        end
    endtask

    // mostly small queries, some squares over the full range, rare large ones
    task automatic test_random_queries();
        int unsigned   i;
        int unsigned   root;
        logic [QW-1:0] n;
        for (i = 0; i < 70; i++) begin
            if (i == 8) begin
                send_idle_pct = 45;
                recv_idle_pct = 27;
            end
            if (i == 41) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (i % 10)
                0, 1, 2, 3, 4, 5: begin
                    n = QW'($urandom_range(255));
                end
                6, 7: begin
                    root = $urandom_range(63);
                    n = QW'(root * root);
                end
                default: begin
                    n = (i == 49 || i == 69) ? QW'($urandom_range(4095))
                                             : QW'($urandom_range(511));
                end
            endcase
            send_query(n);
        end
    endtask

    // long result-side hold while queries keep coming, so the input stalls
    task automatic test_result_stall();
        int unsigned k;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // let the block go idle first so the hold fills it
        s_valid <= 1'b0;
        while (pending_counts.size() != 0) @(posedge aclk);
        hold_cycles_left = 1000;
        for (k = 0; k < 5; k++) begin
            send_query(QW'($urandom_range(40)));
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_corner_queries();
        test_random_queries();
        test_result_stall();
        s_valid <= 1'b0;

        // drain, then let the block settle
        while (pending_counts.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("[min_square_sum_count_top] OK");
        end else begin
            $display("[min_square_sum_count_top] ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/msq_pkg.sv
src/msq_table.sv
src/msq_ctrl.sv
src/min_square_sum_count_top.sv
src/msq_checker.sv
dv/min_square_sum_count_top_tb.sv
